@@ rtl/mkpq_pkg.sv @@
// Package for the min-key priority queue: sizes, command and status codes,
// transaction structs and the occupancy helper. No dependencies.
package mkpq_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int KEY_W       = 8;
  localparam int TAG_W       = 8;
  localparam int OCC_W       = 4;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_EXTRACT = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic             cmd;
    logic [KEY_W-1:0] entry_key;
    logic [TAG_W-1:0] entry_tag;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [KEY_W-1:0] out_key;
    logic [TAG_W-1:0] out_tag;
    logic [OCC_W-1:0] occupancy;
  } out_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  // The reported occupancy is the fill count reduced to its low four bits.
  function automatic logic [OCC_W-1:0] to_occ(input logic [CNT_W-1:0] cnt);
    logic [CNT_W+OCC_W-1:0] ext;
    ext = {{OCC_W{1'b0}}, cnt};
    return ext[OCC_W-1:0];
  endfunction

endpackage

@@ rtl/mkpq_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered
// read data. No package dependencies.
module mkpq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/min_key_priority_queue_core.sv @@
// Top level of the min-key priority queue: command sequencer around the entry RAM.
// Depends on mkpq_pkg and mkpq_ram.
//
// A bounded priority queue of (key, tag) pairs held in arrival order in a single
// synchronous RAM of QUEUE_DEPTH entries with registered read data. An insert
// transaction writes the pair at the tail in the cycle it is accepted and its result
// passes through the response register and then the output register; an insert on a
// full queue is refused with status full. An extract transaction streams the n held
// entries out of the RAM read port, one per cycle, keeping the smallest key found so
// far (the oldest entry wins on equal keys), and then moves every entry behind the
// winner down one place, reading one entry and writing the one before it in each
// cycle. An extract on an empty queue is refused with status empty. Exactly one
// result transaction is produced per input transaction. Results sit in an output
// register, so a new input transaction is taken while an earlier result still waits
// for the consumer; the queue works on one transaction at a time. The RAM needs no
// clearing after reset, as only entries below the fill count are ever used.
module min_key_priority_queue_core
  import mkpq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_RESP  = 2'd3;

  localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_ZERO = '0;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  entry_t           best_r, best_nxt;
  out_t             res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r, out_data_nxt;

  // RAM port signals
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_rdata;

  // Scan helpers
  logic             take;
  logic [IDX_W-1:0] sel_idx;
  entry_t           sel_entry;
  logic [IDX_W-1:0] pos_inc;
  logic             last_pos;

  mkpq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign pos_inc  = pos_r + IDX_ONE;
  // The entry now on the read port is the last one held (before any decrement).
  assign last_pos = ((CNT_W'(pos_r) + CNT_W'(1)) == count_r);

  // A strictly smaller key replaces the running minimum, so the oldest wins ties.
  assign take      = (pos_r == IDX_ZERO) || (ram_rdata.key < best_r.key);
  assign sel_idx   = take ? pos_r : best_idx_r;
  assign sel_entry = take ? ram_rdata : best_r;

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    pos_nxt      = pos_r;
    best_idx_nxt = best_idx_r;
    best_nxt     = best_r;
    res_nxt      = res_r;
    in_ready     = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = pos_r - IDX_ONE;
    ram_wdata    = ram_rdata;
    ram_raddr    = pos_inc;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_data.cmd == CMD_INSERT) begin
            if (count_r == DEPTH_CNT) begin
              res_nxt = '{status: ST_FULL, out_key: '0, out_tag: '0,
                          occupancy: to_occ(count_r)};
            end else begin
              ram_we         = 1'b1;
              ram_waddr      = count_r[IDX_W-1:0];
              ram_wdata.key  = in_data.entry_key;
              ram_wdata.tag  = in_data.entry_tag;
              count_nxt      = count_r + CNT_W'(1);
              res_nxt = '{status: ST_DONE, out_key: '0, out_tag: '0,
                          occupancy: to_occ(count_r + CNT_W'(1))};
            end
            state_nxt = S_RESP;
          end else begin
            if (count_r == '0) begin
              res_nxt = '{status: ST_EMPTY, out_key: '0, out_tag: '0,
                          occupancy: to_occ(count_r)};
              state_nxt = S_RESP;
            end else begin
              ram_raddr = IDX_ZERO;
              pos_nxt   = IDX_ZERO;
              state_nxt = S_SCAN;
            end
          end
        end
      end

      S_SCAN: begin
        best_idx_nxt = sel_idx;
        best_nxt     = sel_entry;
        if (last_pos) begin
          count_nxt = count_r - CNT_W'(1);
          res_nxt = '{status: ST_DONE, out_key: sel_entry.key, out_tag: sel_entry.tag,
                      occupancy: to_occ(count_r - CNT_W'(1))};
          if (sel_idx == pos_r) begin
            state_nxt = S_RESP;
          end else begin
            // Start closing the gap: fetch the entry just behind the winner.
            ram_raddr = sel_idx + IDX_ONE;
            pos_nxt   = sel_idx + IDX_ONE;
            state_nxt = S_SHIFT;
          end
        end else begin
          pos_nxt = pos_inc;
        end
      end

      S_SHIFT: begin
        // Entry at pos_r is on the read port; it moves down one place.
        ram_we = 1'b1;
        if (CNT_W'(pos_r) == count_r) begin
          state_nxt = S_RESP;
        end else begin
          pos_nxt = pos_inc;
        end
      end

      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register: loaded when a result is ready and the slot is free or is being emptied in that cycle.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == S_RESP && (!out_valid_r || out_ready)) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    best_idx_r <= best_idx_nxt;
    best_r     <= best_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
